[rtl/accel_energy_velocity_binner_defines.svh]
// Assertion helpers for the velocity binner.
// Each expects i_clk and i_rst_n in the scope of use.
`ifndef ACCEL_ENERGY_VELOCITY_BINNER_DEFINES_SVH
`define ACCEL_ENERGY_VELOCITY_BINNER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AEVB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define AEVB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/aevb_pkg.sv]
package aevb_pkg;

    localparam int AXIS_W   = 12;
    localparam int ENERGY_W = 24;
    localparam int THR_W    = 32;
    localparam int CNT_W    = 8;
    localparam int VEL_W    = 7;

    localparam logic [CNT_W-1:0] HIT_CAP = 8'd128;
    localparam logic [VEL_W-1:0] VEL_MAX = 7'd127;

    typedef enum logic [2:0] {
        REG_THR_START  = 3'd0,
        REG_THR_STEP   = 3'd1,
        REG_THR_GROWTH = 3'd2,
        REG_FALLOFF    = 3'd3,
        REG_TRIGGER    = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SQ,
        S_WALK,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [CNT_W-1:0] quiet;
        logic [CNT_W-1:0] hit;
    } t_bin_cnt;

endpackage

[rtl/aevb_sqacc.sv]
module aevb_sqacc
    import aevb_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic signed [AXIS_W-1:0]   i_x_axis,
    input  logic signed [AXIS_W-1:0]   i_y_axis,
    input  logic signed [AXIS_W-1:0]   i_z_axis,
    output logic                       o_done,
    output logic [ENERGY_W-1:0]        o_energy
);

    logic signed [AXIS_W-1:0] r_ax [3];
    logic [1:0]               r_step;
    logic                     r_busy;
    logic                     r_done;
    logic [ENERGY_W-1:0]      r_prod;
    logic [ENERGY_W-1:0]      r_acc;

    logic signed [AXIS_W-1:0] sel;
    logic [AXIS_W-1:0]        mag;
    logic [ENERGY_W-1:0]      sq;

    always_comb begin
        unique case (r_step)
            2'd0:    sel = r_ax[0];
            2'd1:    sel = r_ax[1];
            2'd2:    sel = r_ax[2];
            default: sel = '0;
        endcase
        mag = sel[AXIS_W-1] ? AXIS_W'(-sel) : $unsigned(sel);
        sq  = ENERGY_W'(mag) * ENERGY_W'(mag);
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_step == 2'd3);
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == 2'd3) begin
                    r_busy <= 1'b0;
                end else begin
                    r_step <= r_step + 2'd1;
                end
            end
        end
    end

    // one squarer, product registered before it is accumulated
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ax[0] <= i_x_axis;
            r_ax[1] <= i_y_axis;
            r_ax[2] <= i_z_axis;
            r_acc   <= '0;
        end else if (r_busy) begin
            r_prod <= sq;
            if (r_step != 2'd0) begin
                r_acc <= r_acc + r_prod;
            end
        end
    end

    assign o_done   = r_done;
    assign o_energy = r_acc;

endmodule

[rtl/aevb_store.sv]
module aevb_store
    import aevb_pkg::*;
#(
    parameter int NUM_BINS = 100,
    parameter int AW       = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_bin_cnt      o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_bin_cnt      i_wr_data
);

    t_bin_cnt              r_mem [NUM_BINS];
    logic [NUM_BINS-1:0]   r_vld;
    t_bin_cnt              r_rd_data;
    logic                  r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // an entry never written reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

[rtl/accel_energy_velocity_binner.sv]
// Velocity binner: each accepted reading has its energy (sum of the three axis
// squares) formed on one shared squarer, then walks the bins one per cycle through
// a counter memory with one read and one write port, the threshold advancing by
// one add per bin. Input ready is high only while idle. The result sits in an
// output register, so a new reading is taken while the last velocity waits; a
// reading only stalls at its end if that register is still full. Counters come out
// of reset cleared; no clearing pass is needed.
// Configuration registers sit at byte addresses 0, 4, 8, 12 and 16.
`include "accel_energy_velocity_binner_defines.svh"

module accel_energy_velocity_binner
    import aevb_pkg::*;
#(
    parameter int NUM_BINS = 100
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic signed [AXIS_W-1:0] i_x_axis,
    input  logic signed [AXIS_W-1:0] i_y_axis,
    input  logic signed [AXIS_W-1:0] i_z_axis,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [VEL_W-1:0]         o_velocity,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [4:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int CW = $clog2(NUM_BINS + 1);

    // configuration
    logic [THR_W-1:0] r_thr_start;
    logic [THR_W-1:0] r_thr_step;
    logic [THR_W-1:0] r_thr_growth;
    logic [CNT_W-1:0] r_falloff;
    logic [CNT_W-1:0] r_trigger;

    logic [2:0] reg_idx;
    logic       cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_start  <= '0;
            r_thr_step   <= '0;
            r_thr_growth <= '0;
            r_falloff    <= 8'd8;
            r_trigger    <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_THR_START:  r_thr_start  <= pwdata;
                REG_THR_STEP:   r_thr_step   <= pwdata;
                REG_THR_GROWTH: r_thr_growth <= pwdata;
                REG_FALLOFF:    r_falloff    <= pwdata[CNT_W-1:0];
                REG_TRIGGER:    r_trigger    <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_THR_START:  prdata = r_thr_start;
            REG_THR_STEP:   prdata = r_thr_step;
            REG_THR_GROWTH: prdata = r_thr_growth;
            REG_FALLOFF:    prdata = {24'd0, r_falloff};
            REG_TRIGGER:    prdata = {24'd0, r_trigger};
            default:        prdata = '0;
        endcase
    end

    // energy unit
    logic                sq_start;
    logic                sq_done;
    logic [ENERGY_W-1:0] energy;

    aevb_sqacc u_sqacc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (sq_start),
        .i_x_axis (i_x_axis),
        .i_y_axis (i_y_axis),
        .i_z_axis (i_z_axis),
        .o_done   (sq_done),
        .o_energy (energy)
    );

    // bin counter store
    logic          rd_en;
    logic          wr_en;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    t_bin_cnt      rd_data;
    t_bin_cnt      wr_data;

    aevb_store #(
        .NUM_BINS (NUM_BINS),
        .AW       (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    // sequencer and walk state
    t_state           r_state, n_state;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [THR_W-1:0] r_thr, n_thr;
    logic [THR_W-1:0] r_inc, n_inc;
    logic [VEL_W-1:0] r_vel, n_vel;
    logic [VEL_W-1:0] r_o_vel, n_o_vel;
    logic             r_o_valid, n_o_valid;

    logic [CW-1:0]    cnt_m1;
    logic             above;
    logic             active;
    logic [CNT_W-1:0] q1;
    logic [CNT_W-1:0] h1;
    logic [VEL_W-1:0] cnt_vel;

    assign cnt_m1  = r_cnt - CW'(1);
    assign rd_addr = r_cnt[AW-1:0];
    assign wr_addr = cnt_m1[AW-1:0];
    assign cnt_vel = (32'(r_cnt) > 32'(VEL_MAX)) ? VEL_MAX : VEL_W'(r_cnt);

    // update of the bin read last cycle against its threshold
    always_comb begin
        above = {{(THR_W-ENERGY_W){1'b0}}, energy} > r_thr;
        q1    = above ? '0 : rd_data.quiet;
        h1    = rd_data.hit;
        if (above && (rd_data.hit < HIT_CAP)) begin
            h1 = rd_data.hit + 8'd1;
        end
        if (q1 > r_falloff) begin
            h1 = '0;
        end
        active        = h1 > r_trigger;
        wr_data.quiet = q1 + 8'd1;
        wr_data.hit   = h1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt   <= n_cnt;
        r_thr   <= n_thr;
        r_inc   <= n_inc;
        r_vel   <= n_vel;
        r_o_vel <= n_o_vel;
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_thr     = r_thr;
        n_inc     = r_inc;
        n_vel     = r_vel;
        n_o_vel   = r_o_vel;
        n_o_valid = r_o_valid;
        sq_start  = 1'b0;
        rd_en     = 1'b0;
        wr_en     = 1'b0;

        if (r_o_valid && i_out_ready) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    sq_start = 1'b1;
                    n_state  = S_SQ;
                end
            end
            S_SQ: begin
                if (sq_done) begin
                    n_thr   = r_thr_start;
                    n_inc   = r_thr_step;
                    n_cnt   = '0;
                    n_vel   = '0;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                // read bin r_cnt, write back bin r_cnt - 1
                n_thr = r_thr + r_inc;
                n_inc = r_inc + r_thr_growth;
                rd_en = r_cnt < CW'(NUM_BINS);
                wr_en = r_cnt != '0;
                if (wr_en && active) begin
                    n_vel = cnt_vel;
                end
                if (r_cnt == CW'(NUM_BINS)) begin
                    n_state = S_FIN;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            S_FIN: begin
                // hold until the output register is free
                if (!r_o_valid || i_out_ready) begin
                    n_o_vel   = r_vel;
                    n_o_valid = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_o_valid;
    assign o_velocity  = r_o_vel;

    `AEVB_ASSERT_NOW(a_vel_range, o_out_valid, 32'(o_velocity) <= NUM_BINS, "velocity beyond bin count")
    `AEVB_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready, "ready after accept")
    `AEVB_ASSERT_NOW(a_cnt_bound, r_state == S_WALK, 32'(r_cnt) <= NUM_BINS, "bin count overrun")
    `AEVB_ASSERT_NOW(a_sq_done_state, sq_done, r_state == S_SQ, "energy done outside wait")

endmodule

[tb/sv/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import aevb_pkg::*;

    localparam int NUM_BINS          = 100;
    localparam int LAST_REG_SLOT     = 7;
    localparam int ITEMS_PER_SETTING = 180;
    localparam int SETTINGS_PER_MODE = 3;
    localparam int WATCHDOG_LIMIT    = 3000;
    localparam int TAIL_CYCLES       = NUM_BINS + 20;

    typedef enum {BURST_LOUD, BURST_QUIET, BURST_SILENT, BURST_CORNER, BURST_MIXED} t_burst;
    typedef enum {SET_RAMP, SET_SCRAMBLED, SET_EXTREME} t_setting;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic signed [AXIS_W-1:0] i_x_axis;
    logic signed [AXIS_W-1:0] i_y_axis;
    logic signed [AXIS_W-1:0] i_z_axis;
    logic                     o_out_valid;
    logic                     i_out_ready;
    logic [VEL_W-1:0]         o_velocity;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [4:0]               paddr;
    logic [31:0]              pwdata;
    logic [31:0]              prdata;
    logic                     pready;

    // predictor state and register mirror
    logic [CNT_W-1:0] bin_quiet [NUM_BINS];
    logic [CNT_W-1:0] bin_hits [NUM_BINS];
    logic [THR_W-1:0] thr_start_cfg;
    logic [THR_W-1:0] thr_step_cfg;
    logic [THR_W-1:0] thr_growth_cfg;
    logic [CNT_W-1:0] falloff_cfg;
    logic [CNT_W-1:0] trigger_cfg;

    logic [VEL_W-1:0] pending_velocity [$];
    logic [VEL_W-1:0] expected_vel;
    logic signed [AXIS_W-1:0] axis_corners [5] = '{12'h800, 12'h7FF, 12'hFFF, 12'h000, 12'h001};

    int send_idle_pct;
    int recv_stall_pct;
    int mismatch_count;
    int idle_cycles;

    accel_energy_velocity_binner #(.NUM_BINS(NUM_BINS)) uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic void load_reset_state();
        thr_start_cfg  = '0;
        thr_step_cfg   = '0;
        thr_growth_cfg = '0;
        falloff_cfg    = 8'd8;
        trigger_cfg    = '0;
        for (int b = 0; b < NUM_BINS; b++) begin
            bin_quiet[b] = '0;
            bin_hits[b]  = '0;
        end
    endfunction

    function automatic void mirror_register(input int idx, input logic [31:0] value);
        case (idx)
            REG_THR_START:  thr_start_cfg  = value;
            REG_THR_STEP:   thr_step_cfg   = value;
            REG_THR_GROWTH: thr_growth_cfg = value;
            REG_FALLOFF:    falloff_cfg    = value[CNT_W-1:0];
            REG_TRIGGER:    trigger_cfg    = value[CNT_W-1:0];
            default: ;
        endcase
    endfunction

    // Walk every bin against the advancing threshold and update the counters.
    function automatic logic [VEL_W-1:0] predict_velocity(input logic signed [AXIS_W-1:0] x,
                                                          input logic signed [AXIS_W-1:0] y,
                                                          input logic signed [AXIS_W-1:0] z);
        int xs, ys, zs, vel;
        logic [THR_W-1:0] energy, thr, inc;
        xs = x;
        ys = y;
        zs = z;
        energy = THR_W'(xs * xs + ys * ys + zs * zs);
        thr = thr_start_cfg;
        inc = thr_step_cfg;
        vel = 0;
        for (int b = 0; b < NUM_BINS; b++) begin
            thr = thr + inc;
            inc = inc + thr_growth_cfg;
            if (energy > thr) begin
                bin_quiet[b] = '0;
                if (bin_hits[b] < HIT_CAP)
                    bin_hits[b] = bin_hits[b] + 1'b1;
            end
            if (bin_quiet[b] > falloff_cfg)
                bin_hits[b] = '0;
            if (bin_hits[b] > trigger_cfg)
                vel = b + 1;
            bin_quiet[b] = bin_quiet[b] + 1'b1;
        end
        if (vel > VEL_MAX)
            vel = VEL_MAX;
        return VEL_W'(vel);
    endfunction

    task automatic write_register(input int idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = 5'(idx * 4);
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        mirror_register(idx, value);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic send_reading(input logic signed [AXIS_W-1:0] x,
                                input logic signed [AXIS_W-1:0] y,
                                input logic signed [AXIS_W-1:0] z);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_x_axis   = x;
        i_y_axis   = y;
        i_z_axis   = z;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        pending_velocity.push_back(predict_velocity(x, y, z));
    endtask

    // Drop valid and hold until every velocity beat is back.
    task automatic drain_velocities();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_velocity.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic test_axis_corners();
        for (int c = 0; c < 5; c++)
            send_reading(axis_corners[c], axis_corners[c], axis_corners[c]);
        send_reading(12'h800, 12'h000, 12'h7FF);
        send_reading(12'h001, 12'hFFF, 12'h800);
        drain_velocities();
    endtask

    task automatic test_threshold_wrap();
        write_register(REG_THR_START, 32'hFFFF_FF00);
        write_register(REG_THR_STEP, 32'h0000_0080);
        write_register(REG_THR_GROWTH, 32'hFFFF_FFFF);
        write_register(REG_FALLOFF, 32'd0);
        send_reading(12'h7FF, 12'h800, 12'h7FF);
        send_reading(12'h001, 12'h000, 12'h000);
        send_reading(12'h000, 12'h000, 12'h000);
        drain_velocities();
        write_register(REG_THR_START, 32'hFFFF_FFFF);
        write_register(REG_THR_STEP, 32'hFFFF_FFFF);
        send_reading(12'h800, 12'h800, 12'h800);
        send_reading(12'h010, 12'hFF0, 12'h000);
        drain_velocities();
        // increment flips between zero and half range, so the threshold alternates
        write_register(REG_THR_START, 32'd0);
        write_register(REG_THR_STEP, 32'h8000_0000);
        write_register(REG_THR_GROWTH, 32'h8000_0000);
        send_reading(12'h800, 12'h7FF, 12'h800);
        send_reading(12'h001, 12'h000, 12'h000);
        send_reading(12'h000, 12'h000, 12'h000);
        drain_velocities();
    endtask

    task automatic test_unknown_register();
        for (int idx = int'(REG_TRIGGER) + 1; idx <= LAST_REG_SLOT; idx++)
            write_register(idx, 32'hFFFF_FFFF);
        send_reading(12'h7FF, 12'h7FF, 12'h7FF);
        send_reading(12'h000, 12'h000, 12'h000);
        send_reading(AXIS_W'($urandom), AXIS_W'($urandom), AXIS_W'($urandom));
        drain_velocities();
    endtask

    task automatic test_hit_saturation();
        write_register(REG_THR_START, 32'd0);
        write_register(REG_THR_STEP, 32'd0);
        write_register(REG_THR_GROWTH, 32'd0);
        write_register(REG_FALLOFF, 32'd255);
        write_register(REG_TRIGGER, 32'd127);
        // hits only pass the limit once they reach the cap
        for (int n = 0; n < 132; n++)
            send_reading(12'h7FF, AXIS_W'($urandom), AXIS_W'($urandom));
        drain_velocities();
        write_register(REG_TRIGGER, 32'd128);
        for (int n = 0; n < 3; n++)
            send_reading(12'h800, AXIS_W'($urandom), AXIS_W'($urandom));
        drain_velocities();
        write_register(REG_TRIGGER, 32'd255);
        send_reading(12'h800, 12'h800, 12'h800);
        drain_velocities();
    endtask

    task automatic test_quiet_wrap();
        write_register(REG_TRIGGER, 32'd0);
        send_reading(12'h7FF, 12'h000, 12'h000);
        // quiet count runs past 255 and wraps, so the bins stay active
        for (int n = 0; n < 260; n++)
            send_reading(12'h000, 12'h000, 12'h000);
        drain_velocities();
        write_register(REG_FALLOFF, 32'd10);
        for (int n = 0; n < 12; n++)
            send_reading(12'h000, 12'h000, 12'h000);
        drain_velocities();
    endtask

    task automatic program_random_setting(input t_setting kind);
        logic [31:0] start_val, step_val, growth_val;
        case (kind)
            SET_RAMP: begin
                start_val  = $urandom_range(0, 2_000_000);
                step_val   = $urandom_range(1, 250_000);
                growth_val = $urandom_range(0, 4000);
            end
            SET_SCRAMBLED: begin
                start_val  = $urandom;
                step_val   = $urandom;
                growth_val = $urandom;
            end
            default: begin
                start_val  = $urandom_range(1) ? '1 : '0;
                step_val   = $urandom_range(1) ? '1 : '0;
                growth_val = $urandom_range(1) ? '1 : '0;
            end
        endcase
        write_register(REG_THR_START, start_val);
        write_register(REG_THR_STEP, step_val);
        write_register(REG_THR_GROWTH, growth_val);
        case ($urandom_range(3))
            0: write_register(REG_FALLOFF, 32'd0);
            1: write_register(REG_FALLOFF, 32'd255);
            default: write_register(REG_FALLOFF, $urandom_range(1, 24));
        endcase
        case ($urandom_range(5))
            0: write_register(REG_TRIGGER, 32'd255);
            1, 2: write_register(REG_TRIGGER, 32'd0);
            default: write_register(REG_TRIGGER, $urandom_range(1, 12));
        endcase
    endtask

    // Bursts of loud, quiet, silent, corner and mixed readings push bins up to their limits and let them fall off.
    task automatic test_random_traffic(input int send_pct, input int recv_pct);
        int sent, burst_len, pick;
        t_burst style;
        logic signed [AXIS_W-1:0] ax [3];
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int s = 0; s < SETTINGS_PER_MODE; s++) begin
            program_random_setting(t_setting'(s));
            sent = 0;
            while (sent < ITEMS_PER_SETTING) begin
                burst_len = $urandom_range(1, 24);
                pick = $urandom_range(9);
                style = pick < 4 ? BURST_LOUD : pick < 7 ? BURST_QUIET :
                        pick == 7 ? BURST_SILENT : pick == 8 ? BURST_CORNER : BURST_MIXED;
                for (int n = 0; n < burst_len && sent < ITEMS_PER_SETTING; n++) begin
                    for (int k = 0; k < 3; k++) begin
                        case (style)
                            BURST_LOUD:   ax[k] = AXIS_W'($urandom);
                            BURST_QUIET:  ax[k] = AXIS_W'(int'($urandom_range(0, 126)) - 63);
                            BURST_SILENT: ax[k] = '0;
                            BURST_CORNER: ax[k] = axis_corners[$urandom_range(4)];
                            default: ax[k] = $urandom_range(1) ? AXIS_W'($urandom) :
                                             AXIS_W'(int'($urandom_range(0, 126)) - 63);
                        endcase
                    end
                    send_reading(ax[0], ax[1], ax[2]);
                    sent++;
                end
            end
            drain_velocities();
        end
    endtask

    always @(negedge i_clk)
        i_out_ready = ($urandom_range(99) >= recv_stall_pct);

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_velocity.size() == 0) begin
                report_mismatch($sformatf("velocity beat %0d with nothing pending", o_velocity));
            end else begin
                expected_vel = pending_velocity.pop_front();
                if (o_velocity !== expected_vel)
                    report_mismatch($sformatf("velocity %0d, expected %0d",
                                              o_velocity, expected_vel));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (psel && penable)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_x_axis       = '0;
        i_y_axis       = '0;
        i_z_axis       = '0;
        i_out_ready    = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        mismatch_count = 0;
        idle_cycles    = 0;
        send_idle_pct  = 34;
        recv_stall_pct = 46;
        load_reset_state();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_axis_corners();
        test_threshold_wrap();
        test_unknown_register();
        test_hit_saturation();
        test_quiet_wrap();
        test_random_traffic(34, 46);
        test_random_traffic(46, 34);
        test_random_traffic(0, 0);

        drain_velocities();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
